### rtl/core/drtq_pkg.sv
// Shared types and constants for the dirty region tracker queue.
// No dependencies; every module of the block imports this package.
package drtq_pkg;

   localparam int GRID_W      = 5;
   localparam int BUDGET_W    = 4;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 5;
   localparam int COORD_W     = 8;
   localparam int INDEX_W     = 12;
   localparam int CAND_W      = 15;
   localparam int PROD_W      = 10;
   localparam int DRAIN_CAP   = 8;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_GRID_X       = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_Y       = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_Z       = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DRAIN_BUDGET = 2'd3;

   localparam logic FUNC_MARK  = 1'b0;
   localparam logic FUNC_DRAIN = 1'b1;

   typedef struct packed {
      logic               func;
      logic [COORD_W-1:0] block_x;
      logic [COORD_W-1:0] block_y;
      logic [COORD_W-1:0] block_z;
   } req_type;

   typedef struct packed {
      logic [INDEX_W-1:0] region_index;
      logic               last;
   } rsp_type;

   typedef struct packed {
      logic [GRID_W-1:0] x;
      logic [GRID_W-1:0] y;
      logic [GRID_W-1:0] z;
   } grid_type;

   typedef struct packed {
      logic              drain;
      logic [CAND_W-1:0] idx;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } cmd_push_type;

endpackage

### rtl/core/drtq_front.sv
// Front end: takes transactions, finds the enclosing region and its face neighbours,
// and pushes in-grid region indices or drain commands to the command queue. Uses drtq_pkg.
module drtq_front import drtq_pkg::*; #(
   parameter int REGION_EDGE = 16,
   parameter int MAX_REGIONS = 4096
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         accept,
   input  req_type      req_data,
   input  grid_type     grid,
   input  logic         queue_full,
   output cmd_push_type push,
   output logic         busy
);

   localparam int DIV_SHIFT = 16;
   localparam int MULT_W    = DIV_SHIFT + 1;
   localparam int DIVP_W    = COORD_W + MULT_W;
   localparam int DIV_MULT  = (2 ** DIV_SHIFT + REGION_EDGE - 1) / REGION_EDGE;
   localparam int LIM_W     = CAND_W + 2;

   localparam logic [COORD_W-1:0] EDGE_C    = COORD_W'(REGION_EDGE);
   localparam logic [COORD_W-1:0] EDGE_TOP  = COORD_W'(REGION_EDGE - 1);
   localparam logic [LIM_W-1:0]   MAX_LIMIT = LIM_W'(MAX_REGIONS);

   localparam logic [2:0] F_IDLE  = 3'd0;
   localparam logic [2:0] F_DIV   = 3'd1;
   localparam logic [2:0] F_LOC   = 3'd2;
   localparam logic [2:0] F_CAND  = 3'd3;
   localparam logic [2:0] F_DRAIN = 3'd4;

   localparam logic [2:0] SLOT_SELF = 3'd0;
   localparam logic [2:0] SLOT_XM   = 3'd1;
   localparam logic [2:0] SLOT_XP   = 3'd2;
   localparam logic [2:0] SLOT_YM   = 3'd3;
   localparam logic [2:0] SLOT_YP   = 3'd4;
   localparam logic [2:0] SLOT_ZM   = 3'd5;
   localparam logic [2:0] SLOT_ZP   = 3'd6;

   logic [2:0]         state_ff, state_in;
   logic [2:0]         slot_ff, slot_in;
   logic [COORD_W-1:0] bx_ff, bx_in, by_ff, by_in, bz_ff, bz_in;
   logic [COORD_W-1:0] rx_ff, rx_in, ry_ff, ry_in, rz_ff, rz_in;
   logic [5:0]         face_ff, face_in;
   logic               sb_valid_ff, sb_valid_in;
   logic               sb_drain_ff, sb_drain_in;
   logic [PROD_W-1:0]  sb_p_ff, sb_p_in;
   logic [GRID_W-1:0]  sb_cx_ff, sb_cx_in;

   logic [COORD_W-1:0] cx, cy, cz;
   logic [COORD_W-1:0] lx, ly, lz;
   logic               take, in_grid, go;
   logic [CAND_W-1:0]  sb_idx;
   logic               in_range;

   function automatic logic [COORD_W-1:0] quot(input logic [COORD_W-1:0] v);
      logic [DIVP_W-1:0] prod;
      prod = DIVP_W'(v) * DIVP_W'(DIV_MULT);
      return COORD_W'(prod >> DIV_SHIFT);
   endfunction

   function automatic logic [COORD_W-1:0] rem_of(input logic [COORD_W-1:0] b,
                                                 input logic [COORD_W-1:0] r);
      logic [2*COORD_W-1:0] base;
      base = (2*COORD_W)'(r) * (2*COORD_W)'(EDGE_C);
      return b - COORD_W'(base);
   endfunction

   assign go = !queue_full;
   assign lx = rem_of(bx_ff, rx_ff);
   assign ly = rem_of(by_ff, ry_ff);
   assign lz = rem_of(bz_ff, rz_ff);

   always_comb begin
      cx   = rx_ff;
      cy   = ry_ff;
      cz   = rz_ff;
      take = 1'b0;
      case (slot_ff)
         SLOT_SELF: begin
            take = 1'b1;
         end
         SLOT_XM: begin
            take = face_ff[0] && (rx_ff != '0);
            cx   = rx_ff - 1'b1;
         end
         SLOT_XP: begin
            take = face_ff[1];
            cx   = rx_ff + 1'b1;
         end
         SLOT_YM: begin
            take = face_ff[2] && (ry_ff != '0);
            cy   = ry_ff - 1'b1;
         end
         SLOT_YP: begin
            take = face_ff[3];
            cy   = ry_ff + 1'b1;
         end
         SLOT_ZM: begin
            take = face_ff[4] && (rz_ff != '0);
            cz   = rz_ff - 1'b1;
         end
         SLOT_ZP: begin
            take = face_ff[5];
            cz   = rz_ff + 1'b1;
         end
         default: begin
            take = 1'b0;
         end
      endcase
      in_grid = (cx < COORD_W'(grid.x)) && (cy < COORD_W'(grid.y)) &&
                (cz < COORD_W'(grid.z));
   end

   always_comb begin
      state_in    = state_ff;
      slot_in     = slot_ff;
      bx_in       = bx_ff;
      by_in       = by_ff;
      bz_in       = bz_ff;
      rx_in       = rx_ff;
      ry_in       = ry_ff;
      rz_in       = rz_ff;
      face_in     = face_ff;
      sb_valid_in = sb_valid_ff;
      sb_drain_in = sb_drain_ff;
      sb_p_in     = sb_p_ff;
      sb_cx_in    = sb_cx_ff;
      case (state_ff)
         F_IDLE: begin
            if (accept) begin
               bx_in    = req_data.block_x;
               by_in    = req_data.block_y;
               bz_in    = req_data.block_z;
               slot_in  = SLOT_SELF;
               state_in = (req_data.func == FUNC_DRAIN) ? F_DRAIN : F_DIV;
            end
         end
         F_DIV: begin
            rx_in    = quot(bx_ff);
            ry_in    = quot(by_ff);
            rz_in    = quot(bz_ff);
            state_in = F_LOC;
         end
         F_LOC: begin
            face_in  = {lz == EDGE_TOP, lz == '0, ly == EDGE_TOP, ly == '0,
                        lx == EDGE_TOP, lx == '0};
            state_in = F_CAND;
         end
         F_CAND: begin
            if (go) begin
               slot_in = slot_ff + 1'b1;
               if (slot_ff == SLOT_ZP) begin
                  state_in = F_IDLE;
               end
            end
         end
         F_DRAIN: begin
            if (go) begin
               state_in = F_IDLE;
            end
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
      if (go) begin
         sb_valid_in = ((state_ff == F_CAND) && take && in_grid) || (state_ff == F_DRAIN);
         sb_drain_in = (state_ff == F_DRAIN);
         sb_p_in     = PROD_W'(cy[GRID_W-1:0]) * PROD_W'(grid.z) + PROD_W'(cz[GRID_W-1:0]);
         sb_cx_in    = cx[GRID_W-1:0];
      end
   end

   assign sb_idx   = CAND_W'(sb_p_ff) * CAND_W'(grid.x) + CAND_W'(sb_cx_ff);
   assign in_range = LIM_W'(sb_idx) < MAX_LIMIT;

   always_comb begin
      push.valid     = sb_valid_ff && go && (sb_drain_ff || in_range);
      push.cmd.drain = sb_drain_ff;
      push.cmd.idx   = sb_idx;
   end

   assign busy = (state_ff != F_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= F_IDLE;
         sb_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         sb_valid_ff <= sb_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff     <= slot_in;
      bx_ff       <= bx_in;
      by_ff       <= by_in;
      bz_ff       <= bz_in;
      rx_ff       <= rx_in;
      ry_ff       <= ry_in;
      rz_ff       <= rz_in;
      face_ff     <= face_in;
      sb_drain_ff <= sb_drain_in;
      sb_p_ff     <= sb_p_in;
      sb_cx_ff    <= sb_cx_in;
   end

endmodule

### rtl/core/drtq_cmd_queue.sv
// Short command queue between the front end and the back end.
// Uses drtq_pkg for the command type and depth.
module drtq_cmd_queue import drtq_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  cmd_push_type push,
   input  logic         pop,
   output cmd_type      head,
   output logic         empty,
   output logic         full
);

   cmd_type            entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ff, wr_in;
   logic [QPTR_W-1:0]  rd_ff, rd_in;
   logic [QPTR_W:0]    cnt_ff, cnt_in;

   assign empty = (cnt_ff == '0);
   assign full  = (cnt_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign head  = entry_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push.valid) begin
         wr_in = wr_ff + 1'b1;
      end
      if (pop) begin
         rd_in = rd_ff + 1'b1;
      end
      if (push.valid && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push.valid) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         entry_ff[wr_ff] <= push.cmd;
      end
   end

endmodule

### rtl/core/drtq_back.sv
// Back end: owns the dirty map and the pending region FIFO, marks candidates
// and drains regions as results. Uses drtq_pkg.
module drtq_back import drtq_pkg::*; #(
   parameter int MAX_REGIONS = 4096
) (
   input  logic                clock,
   input  logic                reset,
   input  cmd_type             cmd,
   input  logic                cmd_empty,
   output logic                cmd_pop,
   input  logic [BUDGET_W-1:0] drain_budget,
   output logic                clearing,
   output logic                rsp_valid,
   output rsp_type             rsp_data
);

   localparam int IW = $clog2(MAX_REGIONS);
   localparam int CW = IW + 1;
   localparam logic [IW-1:0]       LAST_ADDR  = IW'(MAX_REGIONS - 1);
   localparam logic [CW-1:0]       FULL_COUNT = CW'(MAX_REGIONS);
   localparam logic [BUDGET_W-1:0] CAP        = BUDGET_W'(DRAIN_CAP);
   localparam logic [BUDGET_W-1:0] ONE_LEFT   = BUDGET_W'(1);

   localparam logic [2:0] B_CLEAR = 3'd0;
   localparam logic [2:0] B_IDLE  = 3'd1;
   localparam logic [2:0] B_CHECK = 3'd2;
   localparam logic [2:0] B_READ  = 3'd3;
   localparam logic [2:0] B_EMIT  = 3'd4;

   logic [2:0]          state_ff, state_in;
   logic [IW-1:0]       clr_addr_ff, clr_addr_in;
   logic [IW-1:0]       head_ff, head_in;
   logic [IW-1:0]       tail_ff, tail_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [IW-1:0]       idx_ff, idx_in;
   logic [BUDGET_W-1:0] left_ff, left_in;

   logic                dirty_mem [MAX_REGIONS];
   logic                dirty_rd_ff;
   logic [IW-1:0]       pend_mem [MAX_REGIONS];
   logic [IW-1:0]       pend_rd_ff;

   logic [IW-1:0]       dirty_addr;
   logic                dirty_re, dirty_we, dirty_wdata;
   logic                pend_we, pend_re;
   logic [BUDGET_W-1:0] cap_budget, take_n;

   assign cap_budget = (drain_budget > CAP) ? CAP : drain_budget;
   assign take_n     = (count_ff < CW'(cap_budget)) ? BUDGET_W'(count_ff) : cap_budget;

   always_comb begin
      state_in    = state_ff;
      clr_addr_in = clr_addr_ff;
      head_in     = head_ff;
      tail_in     = tail_ff;
      count_in    = count_ff;
      idx_in      = idx_ff;
      left_in     = left_ff;
      dirty_addr  = '0;
      dirty_re    = 1'b0;
      dirty_we    = 1'b0;
      dirty_wdata = 1'b0;
      pend_we     = 1'b0;
      pend_re     = 1'b0;
      cmd_pop     = 1'b0;
      rsp_valid   = 1'b0;
      case (state_ff)
         B_CLEAR: begin
            dirty_addr  = clr_addr_ff;
            dirty_we    = 1'b1;
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == LAST_ADDR) begin
               state_in = B_IDLE;
            end
         end
         B_IDLE: begin
            if (!cmd_empty) begin
               cmd_pop = 1'b1;
               if (cmd.drain) begin
                  left_in = take_n;
                  if (take_n != '0) begin
                     state_in = B_READ;
                  end
               end else begin
                  idx_in     = IW'(cmd.idx);
                  dirty_addr = IW'(cmd.idx);
                  dirty_re   = 1'b1;
                  state_in   = B_CHECK;
               end
            end
         end
         B_CHECK: begin
            if (!dirty_rd_ff && (count_ff != FULL_COUNT)) begin
               dirty_addr  = idx_ff;
               dirty_we    = 1'b1;
               dirty_wdata = 1'b1;
               pend_we     = 1'b1;
               tail_in     = (tail_ff == LAST_ADDR) ? '0 : tail_ff + 1'b1;
               count_in    = count_ff + 1'b1;
            end
            state_in = B_IDLE;
         end
         B_READ: begin
            pend_re  = 1'b1;
            head_in  = (head_ff == LAST_ADDR) ? '0 : head_ff + 1'b1;
            count_in = count_ff - 1'b1;
            state_in = B_EMIT;
         end
         B_EMIT: begin
            rsp_valid  = 1'b1;
            dirty_addr = pend_rd_ff;
            dirty_we   = 1'b1;
            left_in    = left_ff - 1'b1;
            state_in   = (left_ff == ONE_LEFT) ? B_IDLE : B_READ;
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_data.region_index = INDEX_W'(pend_rd_ff);
      rsp_data.last         = (left_ff == ONE_LEFT);
   end

   assign clearing = (state_ff == B_CLEAR);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= B_CLEAR;
         clr_addr_ff <= '0;
         head_ff     <= '0;
         tail_ff     <= '0;
         count_ff    <= '0;
      end else begin
         state_ff    <= state_in;
         clr_addr_ff <= clr_addr_in;
         head_ff     <= head_in;
         tail_ff     <= tail_in;
         count_ff    <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff  <= idx_in;
      left_ff <= left_in;
   end

   always_ff @(posedge clock) begin
      if (dirty_we) begin
         dirty_mem[dirty_addr] <= dirty_wdata;
      end
      if (dirty_re) begin
         dirty_rd_ff <= dirty_mem[dirty_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (pend_we) begin
         pend_mem[tail_ff] <= idx_ff;
      end
      if (pend_re) begin
         pend_rd_ff <= pend_mem[head_ff];
      end
   end

endmodule

### rtl/core/dirty_region_tracker_queue.sv
// Top level of the dirty region tracker queue: register file, front end,
// command queue and back end. Uses drtq_pkg, drtq_front, drtq_cmd_queue, drtq_back.
//
//   Channel   Ports                                Transfer
//   request   start, busy, req_data                start high while busy low
//   response  rsp_valid, rsp_data                  one cycle strobe, no stall
//   csr       csr_we, csr_index, csr_wdata         csr_we high
//
// After reset the dirty map is swept clear, address by address, with busy high.
// The front end takes a new transaction once back in idle. The back end checks each
// candidate in its idle and check states and drains each region in its read and emit
// states; its single-port dirty map sets the pace, and a full command queue stalls
// the front end. Responses cannot be held off by the receiver.
module dirty_region_tracker_queue import drtq_pkg::*; #(
   parameter int REGION_EDGE = 16,
   parameter int MAX_REGIONS = 4096
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  req_type               req_data,
   output logic                  rsp_valid,
   output rsp_type               rsp_data,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   grid_type            grid_ff, grid_in;
   logic [BUDGET_W-1:0] budget_ff, budget_in;

   logic         front_busy, clearing, accept;
   cmd_push_type push;
   cmd_type      head;
   logic         q_empty, q_full, q_pop;

   assign busy   = front_busy || clearing;
   assign accept = start && !busy;

   always_comb begin
      grid_in   = grid_ff;
      budget_in = budget_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_GRID_X:       grid_in.x = csr_wdata;
            CSR_GRID_Y:       grid_in.y = csr_wdata;
            CSR_GRID_Z:       grid_in.z = csr_wdata;
            CSR_DRAIN_BUDGET: budget_in = csr_wdata[BUDGET_W-1:0];
            default:          budget_in = budget_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_ff.x <= GRID_W'(16);
         grid_ff.y <= GRID_W'(16);
         grid_ff.z <= GRID_W'(16);
         budget_ff <= BUDGET_W'(2);
      end else begin
         grid_ff   <= grid_in;
         budget_ff <= budget_in;
      end
   end

   drtq_front #(
      .REGION_EDGE (REGION_EDGE),
      .MAX_REGIONS (MAX_REGIONS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .req_data   (req_data),
      .grid       (grid_ff),
      .queue_full (q_full),
      .push       (push),
      .busy       (front_busy)
   );

   drtq_cmd_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (q_pop),
      .head  (head),
      .empty (q_empty),
      .full  (q_full)
   );

   drtq_back #(
      .MAX_REGIONS (MAX_REGIONS)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .cmd          (head),
      .cmd_empty    (q_empty),
      .cmd_pop      (q_pop),
      .drain_budget (budget_ff),
      .clearing     (clearing),
      .rsp_valid    (rsp_valid),
      .rsp_data     (rsp_data)
   );

endmodule

### verif/drtq_checker.sv
// Checker for the dirty region tracker queue: mirrors the registers, the dirty map
// and the pending region queue, and compares every response transaction.
// Depends on drtq_pkg; instantiated by tb_top beside the block.
module drtq_checker import drtq_pkg::*; #(
   parameter int REGION_EDGE = 16,
   parameter int MAX_REGIONS = 4096
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic                  busy,
   input  req_type               req_data,
   input  logic                  rsp_valid,
   input  rsp_type               rsp_data,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    error_count,
   output int                    pending_results,
   output int                    queued_regions,
   output int                    checked_results
);

   grid_type            cfg_grid;
   logic [BUDGET_W-1:0] cfg_budget;
   bit                  dirty_map [MAX_REGIONS];
   int                  dirty_queue [$];
   rsp_type             expected_regions [$];
   int                  errors_seen;
   int                  checked_seen;

   function automatic void mark_region(input int rx, input int ry, input int rz);
      int idx;
      if (rx < 0 || ry < 0 || rz < 0) return;
      if (rx >= int'(cfg_grid.x) || ry >= int'(cfg_grid.y) || rz >= int'(cfg_grid.z)) return;
      idx = (ry * int'(cfg_grid.z) + rz) * int'(cfg_grid.x) + rx;
      if (idx >= MAX_REGIONS || dirty_map[idx] || dirty_queue.size() >= MAX_REGIONS) return;
      dirty_map[idx] = 1'b1;
      dirty_queue.push_back(idx);
   endfunction

   function automatic void predict_mark(input req_type item);
      int rx, ry, rz, lx, ly, lz;
      rx = int'(item.block_x) / REGION_EDGE;
      ry = int'(item.block_y) / REGION_EDGE;
      rz = int'(item.block_z) / REGION_EDGE;
      lx = int'(item.block_x) % REGION_EDGE;
      ly = int'(item.block_y) % REGION_EDGE;
      lz = int'(item.block_z) % REGION_EDGE;
      mark_region(rx, ry, rz);
      if (lx == 0) mark_region(rx - 1, ry, rz);
      if (lx == REGION_EDGE - 1) mark_region(rx + 1, ry, rz);
      if (ly == 0) mark_region(rx, ry - 1, rz);
      if (ly == REGION_EDGE - 1) mark_region(rx, ry + 1, rz);
      if (lz == 0) mark_region(rx, ry, rz - 1);
      if (lz == REGION_EDGE - 1) mark_region(rx, ry, rz + 1);
   endfunction

   function automatic void predict_drain();
      int limit, n, idx;
      limit = (int'(cfg_budget) > DRAIN_CAP) ? DRAIN_CAP : int'(cfg_budget);
      n = (dirty_queue.size() < limit) ? dirty_queue.size() : limit;
      for (int k = 0; k < n; k++) begin
         idx = dirty_queue.pop_front();
         dirty_map[idx] = 1'b0;
         expected_regions.push_back('{region_index: INDEX_W'(idx), last: (k == n - 1)});
      end
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         cfg_grid = '{x: 5'd16, y: 5'd16, z: 5'd16};
         cfg_budget = 4'd2;
         foreach (dirty_map[i]) dirty_map[i] = 1'b0;
         dirty_queue.delete();
         expected_regions.delete();
         errors_seen = 0;
         checked_seen = 0;
      end else begin
         if (rsp_valid) begin
            if (expected_regions.size() == 0) begin
               errors_seen++;
               $display("%0t: expected no response, got index %0d last %0b",
                        $time, rsp_data.region_index, rsp_data.last);
            end else begin
               want = expected_regions.pop_front();
               checked_seen++;
               if (rsp_data.region_index !== want.region_index || rsp_data.last !== want.last) begin
                  errors_seen++;
                  $display("%0t: expected index %0d last %0b, got index %0d last %0b", $time,
                           want.region_index, want.last, rsp_data.region_index, rsp_data.last);
               end
            end
         end
         if (csr_we) begin
            case (csr_index)
               CSR_GRID_X:       cfg_grid.x = csr_wdata[GRID_W-1:0];
               CSR_GRID_Y:       cfg_grid.y = csr_wdata[GRID_W-1:0];
               CSR_GRID_Z:       cfg_grid.z = csr_wdata[GRID_W-1:0];
               CSR_DRAIN_BUDGET: cfg_budget = csr_wdata[BUDGET_W-1:0];
               default: ;
            endcase
         end
         if (start && !busy) begin
            if (req_data.func == FUNC_MARK) predict_mark(req_data);
            else predict_drain();
         end
      end
      error_count     <= errors_seen;
      pending_results <= expected_regions.size();
      queued_regions  <= dirty_queue.size();
      checked_results <= checked_seen;
   end

endmodule

### verif/tb_top.sv
// Testbench top for the dirty region tracker queue: drives mark and drain
// transactions and register writes, runs the watchdog and gives the verdict.
// Depends on drtq_pkg, dirty_region_tracker_queue and drtq_checker.
module tb_top;
   import drtq_pkg::*;

   localparam int REGION_EDGE    = 16;
   localparam int MAX_REGIONS    = 4096;
   localparam int WATCHDOG_LIMIT = 16384;
   localparam int SETTLE_CYCLES  = 200;
   localparam int RANDOM_PHASES  = 7;
   localparam int PHASE_ITEMS    = 25;
   localparam int DRAIN_PCT      = 35;
   localparam int COORD_MAX      = (1 << COORD_W) - 1;
   localparam int AXIS_REGIONS   = (COORD_MAX + 1) / REGION_EDGE;

   logic                  clock;
   logic                  reset;
   logic                  start;
   logic                  busy;
   req_type               req_data;
   logic                  rsp_valid;
   rsp_type               rsp_data;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   int error_count;
   int pending_results;
   int queued_regions;
   int checked_results;
   int mark_count;
   int drain_count;
   int setting_count;
   int idle_pct;

   dirty_region_tracker_queue #(
      .REGION_EDGE(REGION_EDGE),
      .MAX_REGIONS(MAX_REGIONS)
   ) u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   drtq_checker #(
      .REGION_EDGE(REGION_EDGE),
      .MAX_REGIONS(MAX_REGIONS)
   ) u_checker (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .error_count(error_count), .pending_results(pending_results),
      .queued_regions(queued_regions), .checked_results(checked_results)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic req_type mark_item(input int x, input int y, input int z);
      return '{func: FUNC_MARK, block_x: COORD_W'(x), block_y: COORD_W'(y), block_z: COORD_W'(z)};
   endfunction

   function automatic req_type drain_item();
      return '{func: FUNC_DRAIN, block_x: '0, block_y: '0, block_z: '0};
   endfunction

   // Coordinates favour region faces so that neighbour regions are exercised.
   function automatic logic [COORD_W-1:0] random_coord();
      case ($urandom_range(0, 2))
         0: return COORD_W'($urandom_range(0, COORD_MAX));
         1: return COORD_W'($urandom_range(0, AXIS_REGIONS - 1) * REGION_EDGE);
         default: return COORD_W'($urandom_range(0, AXIS_REGIONS - 1) * REGION_EDGE
                                  + REGION_EDGE - 1);
      endcase
   endfunction

   function automatic req_type random_item(input int drain_pct);
      req_type item;
      item.func = ($urandom_range(0, 99) < drain_pct) ? FUNC_DRAIN : FUNC_MARK;
      item.block_x = random_coord();
      item.block_y = random_coord();
      item.block_z = random_coord();
      return item;
   endfunction

   task automatic send_transaction(input req_type item);
      if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
         @(negedge clock);
         start <= 1'b0;
         repeat ($urandom_range(0, 8)) @(negedge clock);
      end
      @(negedge clock);
      start    <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (busy) @(posedge clock);
      if (item.func == FUNC_DRAIN) drain_count++;
      else mark_count++;
   endtask

   // Registers change only once every expected response has arrived and the
   // back end has had time to finish any marks still in flight.
   task automatic settle_and_configure(input int gx, input int gy, input int gz, input int budget);
      @(negedge clock);
      start <= 1'b0;
      @(posedge clock);
      while (pending_results != 0 || busy) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= CSR_GRID_X;
      csr_wdata <= CSR_DATA_W'(gx);
      @(negedge clock);
      csr_index <= CSR_GRID_Y;
      csr_wdata <= CSR_DATA_W'(gy);
      @(negedge clock);
      csr_index <= CSR_GRID_Z;
      csr_wdata <= CSR_DATA_W'(gz);
      @(negedge clock);
      csr_index <= CSR_DRAIN_BUDGET;
      csr_wdata <= CSR_DATA_W'(budget);
      @(negedge clock);
      csr_we <= 1'b0;
      setting_count++;
   endtask

   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((start && !busy) || rsp_valid || csr_we) idle_cycles = 0;
         else idle_cycles++;
      end
      $display("%0t: watchdog expired with %0d responses outstanding", $time, pending_results);
      $display("DONE: errors detected");
      $finish;
   end

   initial begin
      int phase;
      int drains_left;
      start         = 1'b0;
      req_data      = '0;
      csr_we        = 1'b0;
      csr_index     = CSR_GRID_X;
      csr_wdata     = '0;
      reset         = 1'b1;
      mark_count    = 0;
      drain_count   = 0;
      setting_count = 1;
      idle_pct      = 20;
      repeat (5) @(negedge clock);
      reset <= 1'b0;

      // Reset settings: empty drain, grid corners, a repeated region, faces.
      send_transaction(drain_item());
      send_transaction(mark_item(0, 0, 0));
      send_transaction(mark_item(COORD_MAX, COORD_MAX, COORD_MAX));
      send_transaction(mark_item(0, 0, 0));
      send_transaction(mark_item(8, 8, 8));
      send_transaction(mark_item(16, 31, 15));
      send_transaction(mark_item(127, 128, 240));
      repeat (4) send_transaction(drain_item());

      settle_and_configure(16, 16, 16, DRAIN_CAP);
      send_transaction(mark_item(15, 15, 15));
      send_transaction(drain_item());

      // A single region: the enclosing region may lie outside while a face
      // neighbour is still inside.
      settle_and_configure(1, 1, 1, 1);
      send_transaction(mark_item(16, 0, 0));
      send_transaction(mark_item(15, 15, 15));
      repeat (3) send_transaction(drain_item());

      // Oversized grid drops indices beyond the store; budget saturates.
      settle_and_configure(31, 31, 31, 15);
      send_transaction(mark_item(COORD_MAX, COORD_MAX, COORD_MAX));
      send_transaction(mark_item(240, 0, 0));
      send_transaction(mark_item(0, 16, 0));
      send_transaction(drain_item());

      // Zero grid size and zero budget.
      settle_and_configure(0, 16, 16, 0);
      send_transaction(mark_item(0, 0, 0));
      send_transaction(drain_item());

      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0: settle_and_configure(16, 16, 16, DRAIN_CAP);
            1: settle_and_configure(1, 1, 16, 3);
            2: settle_and_configure($urandom_range(17, 31), $urandom_range(17, 31),
                                    $urandom_range(17, 31), $urandom_range(9, 15));
            3: settle_and_configure(31, 2, 31, 1);
            default: settle_and_configure($urandom_range(1, 16), $urandom_range(1, 16),
                                          $urandom_range(1, 16), $urandom_range(1, DRAIN_CAP));
         endcase
         idle_pct = (phase == 4) ? 0 : 30;
         repeat (PHASE_ITEMS) send_transaction(random_item(DRAIN_PCT));
      end

      // Empty the queue at full budget with the request side never idle.
      settle_and_configure(16, 16, 16, DRAIN_CAP);
      idle_pct = 0;
      drains_left = MAX_REGIONS / DRAIN_CAP + 100;
      while (queued_regions > 0 && drains_left > 0) begin
         send_transaction(random_item(100));
         drains_left--;
      end

      @(negedge clock);
      start <= 1'b0;
      @(posedge clock);
      while (pending_results != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Covered %0d mark and %0d drain transactions under %0d register settings.",
               mark_count, drain_count, setting_count);
      $display("%0d drained regions were checked, %0d mismatches, %0d never arrived.",
               checked_results, error_count, pending_results);
      if (error_count == 0 && pending_results == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
